@@ hdl/ecp_pkg.sv @@
package ecp_pkg;

   localparam int EXP_W   = 32;
   localparam int REM_W   = 16;
   localparam int ENTRY_W = EXP_W + REM_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_CHK,
      ST_UP_CMP,
      ST_EXP_RD,
      ST_EXP_CHK,
      ST_CONS,
      ST_POP,
      ST_POP_LD,
      ST_DN_CHK,
      ST_DN_RDR,
      ST_DN_CMP,
      ST_FIN_RD,
      ST_FIN_CHK
   } ctl_state_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_UP_CHK,
      OP_UP_CMP,
      OP_EXP_RD,
      OP_EXP_CHK,
      OP_CONS,
      OP_POP,
      OP_POP_LD,
      OP_DN_CHK,
      OP_DN_RDR,
      OP_DN_CMP,
      OP_FIN_RD,
      OP_FIN_CHK
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic insert_ok;
      logic idx_zero;
      logic up_move;
      logic size_zero;
      logic size_one;
      logic expired;
      logic root_multi;
      logic left_in;
      logic dn_move;
      logic after_cons;
   } dp_stat_type;

endpackage

@@ hdl/expiring_credit_pool_edf.sv @@
// Channel   | Ports                                             | Transfer
// ----------+---------------------------------------------------+--------------------------
// request   | start, busy, req_batch_count, req_batch_lifetime  | start high while busy low
// response  | rsp_valid, rsp_consumed, rsp_consumed_total,      | one cycle with rsp_valid
//           | rsp_pool_empty, rsp_insert_dropped                |
//
// Each tick runs through its steps in order: an arriving batch is inserted and
// sifted up toward the root, each expired batch is popped and its replacement
// sifted down, one credit is taken from the root batch if the pool is not empty
// (a batch drained by it is popped and sifted down too), and the result is read
// out. The time taken grows with every expired batch and every heap level, all
// through the single-read heap RAM.
// Synchronous reset empties the heap and clears the tick and total counters at
// once; no clearing pass. Results cannot be stalled: rsp_valid pulses for one
// cycle and busy is already low in that cycle.
module expiring_credit_pool_edf
   import ecp_pkg::*;
   #(parameter int HEAP_DEPTH = 64)
   (input  logic              clock,
    input  logic              reset,
    input  logic              start,
    output logic              busy,
    input  logic [REM_W-1:0]  req_batch_count,
    input  logic [REM_W-1:0]  req_batch_lifetime,
    output logic              rsp_valid,
    output logic              rsp_consumed,
    output logic [EXP_W-1:0]  rsp_consumed_total,
    output logic              rsp_pool_empty,
    output logic              rsp_insert_dropped);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Sequence insert, expiry pops, consume and finish.
   ecp_ctl u_ctl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat));

   // Hold heap, counters and result registers.
   ecp_dp #(.HEAP_DEPTH(HEAP_DEPTH)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .batch_count        (req_batch_count),
      .batch_lifetime     (req_batch_lifetime),
      .rsp_valid          (rsp_valid),
      .rsp_consumed       (rsp_consumed),
      .rsp_consumed_total (rsp_consumed_total),
      .rsp_pool_empty     (rsp_pool_empty),
      .rsp_insert_dropped (rsp_insert_dropped));

endmodule

@@ hdl/ecp_ram.sv @@
module ecp_ram
   #(parameter int WIDTH = 8,
     parameter int DEPTH = 16)
   (input  logic                     clock,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ hdl/ecp_ctl.sv @@
module ecp_ctl
   import ecp_pkg::*;
   (input  logic        clock,
    input  logic        reset,
    input  logic        start,
    output logic        busy,
    output dp_cmd_type  cmd,
    input  dp_stat_type stat);

   ctl_state_type state_ff, state_in;
   ctl_state_type after_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_IDLE;
      busy      = (state_ff != ST_IDLE);
      after_pop = stat.after_cons ? ST_FIN_RD : ST_EXP_RD;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               state_in = stat.insert_ok ? ST_UP_CHK : ST_EXP_RD;
            end
         end
         ST_UP_CHK: begin
            cmd.op   = OP_UP_CHK;
            state_in = stat.idx_zero ? ST_EXP_RD : ST_UP_CMP;
         end
         ST_UP_CMP: begin
            cmd.op   = OP_UP_CMP;
            state_in = stat.up_move ? ST_UP_CHK : ST_EXP_RD;
         end
         ST_EXP_RD: begin
            cmd.op   = OP_EXP_RD;
            state_in = stat.size_zero ? ST_CONS : ST_EXP_CHK;
         end
         ST_EXP_CHK: begin
            cmd.op   = OP_EXP_CHK;
            state_in = stat.expired ? ST_POP : ST_CONS;
         end
         ST_CONS: begin
            cmd.op = OP_CONS;
            if (stat.size_zero || stat.root_multi) begin
               state_in = ST_FIN_RD;
            end else begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            cmd.op   = OP_POP;
            state_in = stat.size_one ? after_pop : ST_POP_LD;
         end
         ST_POP_LD: begin
            cmd.op   = OP_POP_LD;
            state_in = ST_DN_CHK;
         end
         ST_DN_CHK: begin
            cmd.op   = OP_DN_CHK;
            state_in = stat.left_in ? ST_DN_RDR : after_pop;
         end
         ST_DN_RDR: begin
            cmd.op   = OP_DN_RDR;
            state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            cmd.op   = OP_DN_CMP;
            state_in = stat.dn_move ? ST_DN_CHK : after_pop;
         end
         ST_FIN_RD: begin
            cmd.op   = OP_FIN_RD;
            state_in = ST_FIN_CHK;
         end
         ST_FIN_CHK: begin
            cmd.op   = OP_FIN_CHK;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ hdl/ecp_dp.sv @@
module ecp_dp
   import ecp_pkg::*;
   #(parameter int HEAP_DEPTH = 64)
   (input  logic              clock,
    input  logic              reset,
    input  dp_cmd_type        cmd,
    output dp_stat_type       stat,
    input  logic [REM_W-1:0]  batch_count,
    input  logic [REM_W-1:0]  batch_lifetime,
    output logic              rsp_valid,
    output logic              rsp_consumed,
    output logic [EXP_W-1:0]  rsp_consumed_total,
    output logic              rsp_pool_empty,
    output logic              rsp_insert_dropped);

   localparam int IW = $clog2(HEAP_DEPTH);
   localparam int SW = $clog2(HEAP_DEPTH + 1);
   localparam int CW = IW + 2;
   localparam logic [SW-1:0] FULL = SW'(HEAP_DEPTH);

   logic [SW-1:0]      size_ff, size_in;
   logic [EXP_W-1:0]   tick_ff, tick_in;
   logic [EXP_W-1:0]   total_ff, total_in;
   logic               valid_ff, valid_in;
   logic               consumed_ff, consumed_in;
   logic               empty_ff, empty_in;
   logic               dropped_ff, dropped_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [IW-1:0]      par_ff, par_in;
   logic [ENTRY_W-1:0] val_ff, val_in;
   logic [ENTRY_W-1:0] root_ff, root_in;
   logic [ENTRY_W-1:0] cand_ff, cand_in;
   logic               has_r_ff, has_r_in;
   logic               reason_ff, reason_in;

   logic               we;
   logic [IW-1:0]      waddr, raddr;
   logic [ENTRY_W-1:0] wdata, rdata;

   logic [CW-1:0]      left_idx, right_idx;
   logic [IW-1:0]      parent;
   logic               pick_r;
   logic [ENTRY_W-1:0] child;
   logic [IW-1:0]      child_idx;

   ecp_ram #(.WIDTH(ENTRY_W), .DEPTH(HEAP_DEPTH)) u_heap (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_addr (raddr),
      .rd_data (rdata));

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= '0;
         tick_ff  <= '0;
         total_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         size_ff  <= size_in;
         tick_ff  <= tick_in;
         total_ff <= total_in;
         valid_ff <= valid_in;
      end
      consumed_ff <= consumed_in;
      empty_ff    <= empty_in;
      dropped_ff  <= dropped_in;
      idx_ff      <= idx_in;
      par_ff      <= par_in;
      val_ff      <= val_in;
      root_ff     <= root_in;
      cand_ff     <= cand_in;
      has_r_ff    <= has_r_in;
      reason_ff   <= reason_in;
   end

   assign left_idx  = {1'b0, idx_ff, 1'b1};
   assign right_idx = left_idx + CW'(1);
   assign parent    = (idx_ff - IW'(1)) >> 1;
   assign pick_r    = has_r_ff && (rdata < cand_ff);
   assign child     = pick_r ? rdata : cand_ff;
   assign child_idx = pick_r ? right_idx[IW-1:0] : left_idx[IW-1:0];

   always_comb begin
      stat.insert_ok  = (batch_count != '0) && (size_ff != FULL);
      stat.idx_zero   = (idx_ff == '0);
      stat.up_move    = (val_ff < rdata);
      stat.size_zero  = (size_ff == '0);
      stat.size_one   = (size_ff == SW'(1));
      stat.expired    = (rdata[ENTRY_W-1:REM_W] <= tick_ff);
      stat.root_multi = (root_ff[REM_W-1:0] > REM_W'(1));
      stat.left_in    = (left_idx < CW'(size_ff));
      stat.dn_move    = (child < val_ff);
      stat.after_cons = reason_ff;
   end

   always_comb begin
      size_in     = size_ff;
      tick_in     = tick_ff;
      total_in    = total_ff;
      valid_in    = 1'b0;
      consumed_in = consumed_ff;
      empty_in    = empty_ff;
      dropped_in  = dropped_ff;
      idx_in      = idx_ff;
      par_in      = par_ff;
      val_in      = val_ff;
      root_in     = root_ff;
      cand_in     = cand_ff;
      has_r_in    = has_r_ff;
      reason_in   = reason_ff;
      we          = 1'b0;
      waddr       = idx_ff;
      wdata       = val_ff;
      raddr       = '0;
      unique case (cmd.op)
         OP_IDLE: begin
         end
         OP_LOAD: begin
            consumed_in = 1'b0;
            reason_in   = 1'b0;
            dropped_in  = (batch_count != '0) && (size_ff == FULL);
            if (stat.insert_ok) begin
               val_in  = {tick_ff + EXP_W'(batch_lifetime), batch_count};
               idx_in  = size_ff[IW-1:0];
               size_in = size_ff + SW'(1);
            end
         end
         OP_UP_CHK: begin
            if (idx_ff == '0) begin
               we    = 1'b1;
               waddr = '0;
            end else begin
               raddr  = parent;
               par_in = parent;
            end
         end
         OP_UP_CMP: begin
            we = 1'b1;
            if (stat.up_move) begin
               wdata  = rdata;
               idx_in = par_ff;
            end
         end
         OP_EXP_RD: begin
         end
         OP_EXP_CHK: begin
            root_in = rdata;
         end
         OP_CONS: begin
            reason_in = 1'b1;
            if (size_ff != '0) begin
               consumed_in = 1'b1;
               if (total_ff != '1) begin
                  total_in = total_ff + EXP_W'(1);
               end
               if (stat.root_multi) begin
                  we    = 1'b1;
                  waddr = '0;
                  wdata = {root_ff[ENTRY_W-1:REM_W], root_ff[REM_W-1:0] - REM_W'(1)};
               end
            end
         end
         OP_POP: begin
            size_in = size_ff - SW'(1);
            raddr   = size_in[IW-1:0];
         end
         OP_POP_LD: begin
            val_in = rdata;
            idx_in = '0;
         end
         OP_DN_CHK: begin
            if (stat.left_in) begin
               raddr = left_idx[IW-1:0];
            end else begin
               we = 1'b1;
            end
         end
         OP_DN_RDR: begin
            cand_in  = rdata;
            raddr    = right_idx[IW-1:0];
            has_r_in = (right_idx < CW'(size_ff));
         end
         OP_DN_CMP: begin
            we = 1'b1;
            if (stat.dn_move) begin
               wdata  = child;
               idx_in = child_idx;
            end
         end
         OP_FIN_RD: begin
            tick_in = tick_ff + EXP_W'(1);
         end
         OP_FIN_CHK: begin
            empty_in = (size_ff == '0) || (rdata[ENTRY_W-1:REM_W] <= tick_ff);
            valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid          = valid_ff;
   assign rsp_consumed       = consumed_ff;
   assign rsp_consumed_total = total_ff;
   assign rsp_pool_empty     = empty_ff;
   assign rsp_insert_dropped = dropped_ff;

endmodule

@@ hdl/ecp_checker.sv @@
module ecp_checker
   import ecp_pkg::*;
   (input logic             clock,
    input logic             reset,
    input logic             start,
    input logic             busy,
    input logic             rsp_valid,
    input logic             rsp_consumed,
    input logic [EXP_W-1:0] rsp_consumed_total,
    input logic             rsp_pool_empty);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted transfer did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while busy");

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response longer than one cycle");

   a_total_nz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_consumed |-> rsp_consumed_total != '0)
      else $error("consumed with zero total");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_consumed |-> rsp_pool_empty)
      else $error("nothing consumed yet pool not empty");

endmodule

bind expiring_credit_pool_edf ecp_checker u_ecp_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_consumed       (rsp_consumed),
   .rsp_consumed_total (rsp_consumed_total),
   .rsp_pool_empty     (rsp_pool_empty));
